// ----- rtl/tedd_pkg.sv -----
package tedd_pkg;

  // Decoder mode; undecided while the sniff window is still filling
  typedef enum logic [2:0] {
    MODE_UND  = 3'd0,
    MODE_RAW  = 3'd1,
    MODE_UTF8 = 3'd2,
    MODE_LE   = 3'd3,
    MODE_BE   = 3'd4
  } mode_t;

  // Encoding codes shown on the result channel
  localparam logic [1:0] ENC_RAW  = 2'd0;
  localparam logic [1:0] ENC_UTF8 = 2'd1;
  localparam logic [1:0] ENC_LE   = 2'd2;
  localparam logic [1:0] ENC_BE   = 2'd3;

  // Mark bytes
  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;
  localparam logic [7:0] QMARK   = 8'h3F;

  // Results per item are capped
  localparam int          RES_CNT_W   = 7;
  localparam logic [6:0]  MAX_RESULTS = 7'd64;

  // Zero counters only need to know "four or more"
  localparam logic [2:0]  ZCNT_SAT = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic take;         // latch the input transfer
    logic absorb;       // process the latched byte
    logic flush_start;  // decide mode and start the window flush
    logic flush_read;   // read one window byte
    logic flush_feed;   // decode the byte just read
    logic finish;       // push the held result, close the file on end
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_end;
    logic mode_und;
    logic win_full;
    logic seen_any;
    logic flush_done;
    logic feed_stall;
    logic fin_stall;
  } sts_t;

  function automatic logic [1:0] enc_of(mode_t m);
    logic [1:0] e;
    e = ENC_RAW;
    case (m)
      MODE_UTF8: e = ENC_UTF8;
      MODE_LE:   e = ENC_LE;
      MODE_BE:   e = ENC_BE;
      default:   e = ENC_RAW;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/tedd_in_if.sv -----
interface tedd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       has_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output has_byte, output end_of_stream,
                  input ready);
  modport sink   (input valid, input in_byte, input has_byte, input end_of_stream,
                  output ready);
endinterface

// ----- rtl/tedd_out_if.sv -----
interface tedd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       last_result;
  logic [1:0] encoding;

  modport source (output valid, output out_char, output has_char, output last_result,
                  output encoding, input ready);
  modport sink   (input valid, input out_char, input has_char, input last_result,
                  input encoding, output ready);
endinterface

// ----- rtl/tedd_ctrl.sv -----
module tedd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tedd_pkg::sts_t sts,
  output tedd_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ABSORB  = 6'b000010,
    S_CHECK   = 6'b000100,
    S_FL_READ = 6'b001000,
    S_FL_DATA = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence one item: absorb, optional window flush, finish
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_ABSORB;
        end
      end
      S_ABSORB: begin
        if (!sts.feed_stall) begin
          cmd.absorb = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.mode_und && (sts.win_full || (sts.item_end && sts.seen_any))) begin
          cmd.flush_start = 1'b1;
          state_nxt       = S_FL_READ;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FL_READ: begin
        if (sts.flush_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.flush_read = 1'b1;
          state_nxt      = S_FL_DATA;
        end
      end
      S_FL_DATA: begin
        if (!sts.feed_stall) begin
          cmd.flush_feed = 1'b1;
          state_nxt      = S_FL_READ;
        end
      end
      S_FINISH: begin
        if (!sts.fin_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/tedd_dp.sv -----
module tedd_dp #(
  parameter int SNIFF_WINDOW = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tedd_pkg::cmd_t cmd,
  output tedd_pkg::sts_t sts,
  input  logic [7:0]     in_byte,
  input  logic           has_byte,
  input  logic           end_of_stream,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_char,
  output logic           has_char,
  output logic           last_result,
  output logic [1:0]     encoding
);

  localparam int AW = (SNIFF_WINDOW > 1) ? $clog2(SNIFF_WINDOW) : 1;
  localparam int CW = $clog2(SNIFF_WINDOW + 1);

  // Window memory
  logic [7:0] win_mem [SNIFF_WINDOW];

  // Latched item
  logic [7:0] byte_r, byte_nxt;
  logic       has_r, has_nxt;
  logic       end_r, end_nxt;

  // Sniff and decode state
  tedd_pkg::mode_t mode_r, mode_nxt;
  logic [CW-1:0]   seen_r, seen_nxt;
  logic [2:0]      oddz_r, oddz_nxt;
  logic [2:0]      evenz_r, evenz_nxt;
  logic [7:0]      head0_r, head0_nxt;
  logic [7:0]      head1_r, head1_nxt;
  logic [7:0]      head2_r, head2_nxt;
  logic [7:0]      held_r, held_nxt;
  logic            phase_r, phase_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            flush_r, flush_nxt;
  logic [7:0]      rd_data_r;
  logic [tedd_pkg::RES_CNT_W-1:0] n_r, n_nxt;

  // Held result, released once the next one or the item end is known
  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_char_r, pend_char_nxt;
  logic       pend_has_r, pend_has_nxt;
  logic [1:0] pend_enc_r, pend_enc_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_has_r, out_has_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] out_enc_r, out_enc_nxt;

  logic        out_free;
  logic [7:0]  feed_byte;
  logic [15:0] unit;
  logic        is_utf16;
  logic        want_emit;
  logic        can_emit;
  logic [7:0]  feed_char;
  logic        feed_go;
  logic        do_feed;
  logic        mem_we;
  tedd_pkg::mode_t dec_mode;
  logic [CW-1:0]   dec_start;

  assign out_free = !out_valid_r || out_ready;

  // Decode one byte in the current mode; window data while flushing
  assign feed_byte = flush_r ? rd_data_r : byte_r;
  assign is_utf16  = (mode_r == tedd_pkg::MODE_LE) || (mode_r == tedd_pkg::MODE_BE);
  assign unit      = (mode_r == tedd_pkg::MODE_LE) ? {feed_byte, held_r} : {held_r, feed_byte};
  assign want_emit = is_utf16 ? (phase_r && (unit != 16'd0)) : 1'b1;
  assign feed_char = !is_utf16 ? feed_byte :
                     ((unit[15:8] == 8'd0) ? unit[7:0] : tedd_pkg::QMARK);
  assign can_emit  = want_emit && (n_r != tedd_pkg::MAX_RESULTS);
  assign feed_go   = flush_r || (has_r && (mode_r != tedd_pkg::MODE_UND));
  assign do_feed   = (cmd.absorb && has_r && (mode_r != tedd_pkg::MODE_UND)) || cmd.flush_feed;
  assign mem_we    = cmd.absorb && has_r && (mode_r == tedd_pkg::MODE_UND);

  // Mode decision at flush time
  always_comb begin
    dec_mode  = tedd_pkg::MODE_RAW;
    dec_start = '0;
    if ((seen_r >= CW'(4)) && (oddz_r == tedd_pkg::ZCNT_SAT)) begin
      dec_mode = tedd_pkg::MODE_LE;
    end else if ((seen_r >= CW'(4)) && (evenz_r == tedd_pkg::ZCNT_SAT)) begin
      dec_mode = tedd_pkg::MODE_BE;
    end else if ((seen_r >= CW'(3)) && (head0_r == tedd_pkg::BYTE_EF) &&
                 (head1_r == tedd_pkg::BYTE_BB) && (head2_r == tedd_pkg::BYTE_BF)) begin
      dec_mode  = tedd_pkg::MODE_UTF8;
      dec_start = CW'(3);
    end
  end

  // Status
  always_comb begin
    sts            = '0;
    sts.item_end   = end_r;
    sts.mode_und   = (mode_r == tedd_pkg::MODE_UND);
    sts.win_full   = (seen_r == CW'(SNIFF_WINDOW));
    sts.seen_any   = (seen_r != '0);
    sts.flush_done = (idx_r == seen_r);
    sts.feed_stall = feed_go && can_emit && pend_valid_r && !out_free;
    sts.fin_stall  = (pend_valid_r || end_r) && !out_free;
  end

  // Next-state logic
  always_comb begin
    byte_nxt       = byte_r;
    has_nxt        = has_r;
    end_nxt        = end_r;
    mode_nxt       = mode_r;
    seen_nxt       = seen_r;
    oddz_nxt       = oddz_r;
    evenz_nxt      = evenz_r;
    head0_nxt      = head0_r;
    head1_nxt      = head1_r;
    head2_nxt      = head2_r;
    held_nxt       = held_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    flush_nxt      = flush_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_char_nxt  = pend_char_r;
    pend_has_nxt   = pend_has_r;
    pend_enc_nxt   = pend_enc_r;
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    out_enc_nxt    = out_enc_r;

    // Drop the output once transferred
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Latch the input transfer
    if (cmd.take) begin
      byte_nxt = in_byte;
      has_nxt  = has_byte;
      end_nxt  = end_of_stream;
      n_nxt    = '0;
    end

    // Sniff: store, count zeros, look for a UTF-16 mark
    if (mem_we) begin
      seen_nxt = seen_r + CW'(1);
      if (byte_r == 8'd0) begin
        if (seen_r[0]) begin
          if (oddz_r != tedd_pkg::ZCNT_SAT) oddz_nxt = oddz_r + 3'd1;
        end else begin
          if (evenz_r != tedd_pkg::ZCNT_SAT) evenz_nxt = evenz_r + 3'd1;
        end
      end
      if (seen_r == CW'(0)) head0_nxt = byte_r;
      if (seen_r == CW'(1)) head1_nxt = byte_r;
      if (seen_r == CW'(2)) head2_nxt = byte_r;
      if (seen_r == CW'(1)) begin
        if ((head0_r == tedd_pkg::BYTE_FF) && (byte_r == tedd_pkg::BYTE_FE)) begin
          mode_nxt = tedd_pkg::MODE_LE;
        end else if ((head0_r == tedd_pkg::BYTE_FE) && (byte_r == tedd_pkg::BYTE_FF)) begin
          mode_nxt = tedd_pkg::MODE_BE;
        end
      end
    end

    // Decode a byte; a new result pushes the held one out
    if (do_feed) begin
      if (is_utf16) begin
        if (!phase_r) begin
          held_nxt  = feed_byte;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
        end
      end
      if (can_emit) begin
        n_nxt = n_r + tedd_pkg::RES_CNT_W'(1);
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pend_char_r;
          out_has_nxt   = pend_has_r;
          out_last_nxt  = 1'b0;
          out_enc_nxt   = pend_enc_r;
        end
        pend_valid_nxt = 1'b1;
        pend_char_nxt  = feed_char;
        pend_has_nxt   = 1'b1;
        pend_enc_nxt   = tedd_pkg::enc_of(mode_r);
      end
    end

    // Start the window flush
    if (cmd.flush_start) begin
      mode_nxt  = dec_mode;
      idx_nxt   = dec_start;
      phase_nxt = 1'b0;
      flush_nxt = 1'b1;
    end

    // Advance the flush index
    if (cmd.flush_feed) begin
      idx_nxt = idx_r + CW'(1);
    end

    // Close the item: release the held result or a bare end marker
    if (cmd.finish) begin
      flush_nxt = 1'b0;
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_char_nxt   = pend_char_r;
        out_has_nxt    = pend_has_r;
        out_last_nxt   = end_r;
        out_enc_nxt    = pend_enc_r;
        pend_valid_nxt = 1'b0;
      end else if (end_r) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = 8'd0;
        out_has_nxt   = 1'b0;
        out_last_nxt  = 1'b1;
        out_enc_nxt   = tedd_pkg::enc_of(mode_r);
      end
      if (end_r) begin
        mode_nxt  = tedd_pkg::MODE_UND;
        seen_nxt  = '0;
        oddz_nxt  = '0;
        evenz_nxt = '0;
        held_nxt  = '0;
        phase_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= tedd_pkg::MODE_UND;
      seen_r       <= '0;
      oddz_r       <= '0;
      evenz_r      <= '0;
      held_r       <= '0;
      phase_r      <= 1'b0;
      flush_r      <= 1'b0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      end_r        <= 1'b0;
      has_r        <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      seen_r       <= seen_nxt;
      oddz_r       <= oddz_nxt;
      evenz_r      <= evenz_nxt;
      held_r       <= held_nxt;
      phase_r      <= phase_nxt;
      flush_r      <= flush_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      end_r        <= end_nxt;
      has_r        <= has_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    head0_r     <= head0_nxt;
    head1_r     <= head1_nxt;
    head2_r     <= head2_nxt;
    idx_r       <= idx_nxt;
    pend_char_r <= pend_char_nxt;
    pend_has_r  <= pend_has_nxt;
    pend_enc_r  <= pend_enc_nxt;
    out_char_r  <= out_char_nxt;
    out_has_r   <= out_has_nxt;
    out_last_r  <= out_last_nxt;
    out_enc_r   <= out_enc_nxt;
  end

  // Window write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[seen_r[AW-1:0]] <= byte_r;
    end
    if (cmd.flush_read) begin
      rd_data_r <= win_mem[idx_r[AW-1:0]];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign has_char    = out_has_r;
  assign last_result = out_last_r;
  assign encoding    = out_enc_r;

endmodule

// ----- rtl/text_encoding_detect_decode.sv -----
// Channel | Dir | Payload                                         | Transfer
// in_ch   | in  | in_byte[7:0], has_byte, end_of_stream           | valid & ready
// out_ch  | out | out_char[7:0], has_char, last_result, encoding  | valid & ready
//
// Steps: an item passes through accept, absorb, check and finish; the item that
// fills the window or ends an undecided file adds a flush: per window byte, one
// read of the window memory and one decode step.
// Reset: synchronous, active low; the window memory is not cleared.
// Stalls: one result is held back until the next is known (to mark the last),
// and an output register lets the next item be accepted while a result waits.
module text_encoding_detect_decode #(
  parameter int SNIFF_WINDOW = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  tedd_in_if.sink      in_ch,
  tedd_out_if.source   out_ch
);

  tedd_pkg::cmd_t cmd;
  tedd_pkg::sts_t sts;

  tedd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tedd_dp #(
    .SNIFF_WINDOW (SNIFF_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_byte       (in_ch.in_byte),
    .has_byte      (in_ch.has_byte),
    .end_of_stream (in_ch.end_of_stream),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char      (out_ch.out_char),
    .has_char      (out_ch.has_char),
    .last_result   (out_ch.last_result),
    .encoding      (out_ch.encoding)
  );

endmodule
